/* rtl/oscillator_trim_calibrator_unit_assert.svh */
// Assertion macros used by the checker module of the trim calibrator.
`ifndef OSCILLATOR_TRIM_CALIBRATOR_UNIT_ASSERT_SVH
`define OSCILLATOR_TRIM_CALIBRATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define OTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/otc_pkg.sv */
// Types and constants of the oscillator trim calibrator.
`timescale 1ns / 1ps

package otc_pkg;

    localparam logic [15:0] TARGET_RST = 16'd12800;
    localparam logic [7:0]  TRIM_RST   = 8'((192 + 256) / 2);
    localparam logic [7:0]  STEP_RST   = 8'((256 - 192) / 2);

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_TRIM   = 2'd1;
    localparam logic [1:0] REG_STEP   = 2'd2;

    // Input word kinds
    localparam logic OP_START = 1'b0;
    localparam logic OP_COUNT = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_DISCARD = 6'b000010,
        PH_SEARCH  = 6'b000100,
        PH_CENTRE  = 6'b001000,
        PH_PLUS    = 6'b010000,
        PH_MINUS   = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [15:0] target_count;
        logic [7:0]  initial_trim;
        logic [7:0]  initial_step;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  trim;
        logic        done_res;
        logic [15:0] abs_error;
    } t_res;

endpackage

/* rtl/oscillator_trim_calibrator_unit.sv */
// Top level of the oscillator trim calibrator: stream channels and register port.
//
// Usage: send a start word (tuser 0) to begin, then one word per reference
// period (tuser 1, tdata = clocks counted at the trim last put out). Every
// input word yields exactly one result word: the trim to apply next, a done
// flag in tuser, and the absolute error of that count against target_count (0 for a start word).
// Registers target_count (0x0), initial_trim (0x4) and initial_step (0x8) are
// written over the APB port, by the user only while no word is in flight;
// the block itself does not enforce this. Reads return them.
// A word is registered on entry and its result is then registered in the
// result register, which holds it until the receiver takes it.
// Throughput: one word per cycle while the receiver keeps up, set by the
// single compare/add update of the search state between the two registers.
// Stall: while the result is held, the entry register still takes one word;
// s_axis_tready falls only when both registers are full and m_axis_tready low.
// Reset: registers return to their defaults, the search goes idle with trim
// 224, and both pipeline registers are emptied.
`timescale 1ns / 1ps

module oscillator_trim_calibrator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] period_count
    input  logic [0:0]  s_axis_tuser,   // [0] op
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] trim, [23:8] abs_error
    output logic [0:0]  m_axis_tuser,   // [0] done_res
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import otc_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic        r_in_op;
    logic [15:0] r_in_count;
    logic        r_out_valid;
    t_res        r_out;
    t_res        step_res;
    logic        advance;
    logic        wr_en;

    assign pready        = 1'b1;
    assign wr_en         = psel && penable && pwrite;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        case (paddr[3:2])
            REG_TARGET: prdata = {16'd0, r_cfg.target_count};
            REG_TRIM:   prdata = {24'd0, r_cfg.initial_trim};
            REG_STEP:   prdata = {24'd0, r_cfg.initial_step};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_count <= TARGET_RST;
            r_cfg.initial_trim <= TRIM_RST;
            r_cfg.initial_step <= STEP_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_TARGET: r_cfg.target_count <= pwdata[15:0];
                REG_TRIM:   r_cfg.initial_trim <= pwdata[7:0];
                REG_STEP:   r_cfg.initial_step <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    otc_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_op    (r_in_op),
        .i_count (r_in_count),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    // entry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op    <= s_axis_tuser[0];
            r_in_count <= s_axis_tdata;
        end
    end

    // result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {r_out.abs_error, r_out.trim};
    assign m_axis_tuser[0] = r_out.done_res;

endmodule

/* rtl/otc_step.sv */
// Calibration state and the per-word update of the trim search.
`timescale 1ns / 1ps

module otc_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic          i_op,
    input  logic [15:0]   i_count,
    input  otc_pkg::t_cfg i_cfg,
    output otc_pkg::t_res o_res
);
    import otc_pkg::*;

    t_phase      r_phase,        n_phase;
    logic [7:0]  r_trim,         n_trim;
    logic [7:0]  r_step,         n_step;
    logic [7:0]  r_centre_trim,  n_centre_trim;
    logic [15:0] r_centre_error, n_centre_error;
    logic [15:0] r_plus_error,   n_plus_error;
    logic        r_finished,     n_finished;

    logic        count_low;
    logic [15:0] err;
    logic [15:0] diff;

    always_comb begin
        count_low = i_count < i_cfg.target_count;
        diff      = count_low ? (i_cfg.target_count - i_count)
                              : (i_count - i_cfg.target_count);
        err       = (i_op == OP_START) ? 16'd0 : diff;

        n_phase        = r_phase;
        n_trim         = r_trim;
        n_step         = r_step;
        n_centre_trim  = r_centre_trim;
        n_centre_error = r_centre_error;
        n_plus_error   = r_plus_error;
        n_finished     = r_finished;

        if (i_op == OP_START) begin
            n_trim     = i_cfg.initial_trim;
            n_step     = i_cfg.initial_step;
            n_finished = 1'b0;
            n_phase    = PH_DISCARD;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_DISCARD: begin
                    n_phase = PH_SEARCH;
                end
                PH_SEARCH: begin
                    n_trim = count_low ? (r_trim - r_step) : (r_trim + r_step);
                    n_step = r_step >> 1;
                    if (n_step == 8'd0) begin
                        n_phase = PH_CENTRE;
                    end
                end
                PH_CENTRE: begin
                    n_centre_trim  = r_trim;
                    n_centre_error = err;
                    n_trim         = r_trim + 8'd1;
                    n_phase        = PH_PLUS;
                end
                PH_PLUS: begin
                    n_plus_error = err;
                    n_trim       = r_centre_trim - 8'd1;
                    n_phase      = PH_MINUS;
                end
                PH_MINUS: begin
                    // minus beats plus, plus beats centre on a tie
                    if (err <= r_centre_error && err <= r_plus_error) begin
                        n_trim = r_centre_trim - 8'd1;
                    end else if (r_plus_error <= r_centre_error
                                 && r_plus_error <= err) begin
                        n_trim = r_centre_trim + 8'd1;
                    end else begin
                        n_trim = r_centre_trim;
                    end
                    n_finished = 1'b1;
                    n_phase    = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        o_res.trim      = n_trim;
        o_res.done_res  = n_finished;
        o_res.abs_error = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_trim         <= TRIM_RST;
            r_step         <= 8'd0;
            r_centre_trim  <= 8'd0;
            r_centre_error <= 16'd0;
            r_plus_error   <= 16'd0;
            r_finished     <= 1'b0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_trim         <= n_trim;
            r_step         <= n_step;
            r_centre_trim  <= n_centre_trim;
            r_centre_error <= n_centre_error;
            r_plus_error   <= n_plus_error;
            r_finished     <= n_finished;
        end
    end

endmodule

/* rtl/otc_checker.sv */
// Port-level checks of the trim calibrator, bound to the top level.
`timescale 1ns / 1ps
`include "oscillator_trim_calibrator_unit_assert.svh"

module otc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);
    import otc_pkg::*;

    // a stalled result word holds
    `OTC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // input side never stalls while the receiver is taking words
    `OTC_ASSERT_NOW(a_no_stall, i_clk, i_rst_n, m_axis_tready, s_axis_tready)

    // a written target reads back
    `OTC_ASSERT_NOW(a_target_rb, i_clk, i_rst_n, $past(psel && penable && pwrite && paddr[3:2] == REG_TARGET) && paddr[3:2] == REG_TARGET, prdata[15:0] == $past(pwdata[15:0]))

endmodule

bind oscillator_trim_calibrator_unit otc_checker u_otc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);

/* tb/oscillator_trim_calibrator_unit_test.sv */
// Self-checking stream and register test of the oscillator trim calibrator.
`timescale 1ns / 1ps

module oscillator_trim_calibrator_unit_test;
    import otc_pkg::*;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [15:0] period_count
    logic [0:0]  s_axis_tuser = '0;    // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] trim, [23:8] abs_error
    logic [0:0]  m_axis_tuser;         // [0] done_res
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    oscillator_trim_calibrator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    typedef struct {
        logic       op;
        logic [15:0] cnt;
        bit         lit;
        t_res       res;
    } t_dir_row;

    // Calibrator model state and its copy of the registers
    t_cfg        cfg = '{target_count: TARGET_RST, initial_trim: TRIM_RST,
                         initial_step: STEP_RST};
    t_phase      ph = PH_IDLE;
    logic [7:0]  cur_trim = TRIM_RST;
    logic [7:0]  step_left = '0;
    logic [7:0]  mid_trim = '0;
    logic [15:0] mid_err = '0;
    logic [15:0] up_err = '0;
    logic        done_flag = 1'b0;

    t_res     trim_expect_q[$];
    t_dir_row dir_rows[$];
    int       mismatch_count = 0;
    int       words_sent = 0;
    int       words_checked = 0;
    int       config_sets = 0;
    int       burst_left = 0;
    int       rx_mode = 0;
    int       rx_tick = 0;
    int       last_delta = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("oscillator_trim_calibrator_unit_test: FAIL");
        $finish;
    end

    task automatic report_miss(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: %s", what);
    endtask

    function automatic t_res calib_predict(input logic op, input logic [15:0] cnt);
        logic [15:0] err;
        t_res        r;
        err = '0;
        if (op == OP_START) begin
            cur_trim  = cfg.initial_trim;
            step_left = cfg.initial_step;
            done_flag = 1'b0;
            ph        = PH_DISCARD;
        end else begin
            err = (cnt > cfg.target_count) ? cnt - cfg.target_count
                                           : cfg.target_count - cnt;
            case (ph)
                PH_DISCARD: ph = PH_SEARCH;
                PH_SEARCH: begin
                    if (cnt < cfg.target_count) cur_trim = cur_trim - step_left;
                    else cur_trim = cur_trim + step_left;
                    step_left = step_left >> 1;
                    if (step_left == 8'd0) ph = PH_CENTRE;
                end
                PH_CENTRE: begin
                    mid_trim = cur_trim;
                    mid_err  = err;
                    cur_trim = mid_trim + 8'd1;
                    ph       = PH_PLUS;
                end
                PH_PLUS: begin
                    up_err   = err;
                    cur_trim = mid_trim - 8'd1;
                    ph       = PH_MINUS;
                end
                PH_MINUS: begin
                    // ties: minus beats plus, plus beats centre
                    if (err <= mid_err && err <= up_err) cur_trim = mid_trim - 8'd1;
                    else if (up_err <= mid_err && up_err <= err) cur_trim = mid_trim + 8'd1;
                    else cur_trim = mid_trim;
                    done_flag = 1'b1;
                    ph        = PH_IDLE;
                end
                default: ph = PH_IDLE;
            endcase
        end
        r.trim      = cur_trim;
        r.done_res  = done_flag;
        r.abs_error = err;
        return r;
    endfunction

    function automatic logic [15:0] pick_count();
        int sel;
        int d;
        sel = $urandom_range(0, 99);
        if (sel < 10) d = 0;
        else if (sel < 45) d = int'($urandom_range(0, 40)) - 20;
        else if (sel < 65) d = -last_delta;   // mirror the last offset to force ties
        else if (sel < 80) d = int'($urandom_range(0, 4000)) - 2000;
        else return 16'($urandom);
        last_delta = d;
        return 16'(int'(cfg.target_count) + d);
    endfunction

    task automatic add_row(input logic op, input logic [15:0] cnt, input bit lit,
                           input logic [7:0] trim, input logic done, input logic [15:0] err);
        t_dir_row row;
        row.op  = op;
        row.cnt = cnt;
        row.lit = lit;
        row.res = '{trim: trim, done_res: done, abs_error: err};
        dir_rows.push_back(row);
    endtask

    // Called just after a rising edge; returns just after the edge that took the word, or after an idle gap.
    task automatic send_word(input logic op, input logic [15:0] cnt, input bit lit,
                             input t_res lit_res);
        t_res pred;
        int   gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= cnt;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = calib_predict(op, cnt);
        trim_expect_q.push_back(lit ? lit_res : pred);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] mask;
        case (idx)
            REG_TARGET: begin
                mask = 32'h0000_FFFF;
                cfg.target_count = val[15:0];
            end
            REG_TRIM: begin
                mask = 32'h0000_00FF;
                cfg.initial_trim = val[7:0];
            end
            default: begin
                mask = 32'h0000_00FF;
                cfg.initial_step = val[7:0];
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // read back from the same address
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if ((prdata & mask) != (val & mask))
            report_miss($sformatf("register %0d reads %h, wrote %h", idx, prdata & mask,
                                  val & mask));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (trim_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [15:0] tgt, input logic [7:0] trm,
                                input logic [7:0] stp);
        wait_drained();
        write_reg(REG_TARGET, {16'h0, tgt});
        write_reg(REG_TRIM, {24'h0, trm});
        write_reg(REG_STEP, {24'h0, stp});
        config_sets++;
    endtask

    task automatic run_random(input int n_items);
        int          done_here;
        int          pick;
        int          len;
        logic [7:0]  s;
        done_here = 0;
        while (done_here < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                // one calibration: discard, one count per halving, then three neighbours; at times cut short or overrun
                len = 0;
                s = cfg.initial_step;
                while (s != 8'd0) begin
                    len++;
                    s = s >> 1;
                end
                if (len == 0) len = 1;
                len = len + 4;
                if ($urandom_range(0, 6) == 0) len = $urandom_range(0, len - 1);
                else if ($urandom_range(0, 9) == 0) len = len + $urandom_range(1, 3);
                send_word(OP_START, 16'($urandom), 1'b0, '0);
                repeat (len) send_word(OP_COUNT, pick_count(), 1'b0, '0);
                done_here += len + 1;
            end else if (pick < 92) begin
                send_word(OP_COUNT, 16'($urandom), 1'b0, '0);
                done_here++;
            end else begin
                send_word(OP_START, 16'($urandom), 1'b0, '0);
                done_here++;
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Result checker and receiver stall pattern
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_checked++;
            if (trim_expect_q.size() == 0) begin
                report_miss("result word with nothing expected");
            end else begin
                want = trim_expect_q.pop_front();
                if (m_axis_tdata[7:0] !== want.trim || m_axis_tuser[0] !== want.done_res ||
                    m_axis_tdata[23:8] !== want.abs_error)
                    report_miss($sformatf(
                        "word %0d exp trim %0d done %0b err %0d, got trim %0d done %0b err %0d",
                        words_checked, want.trim, want.done_res, want.abs_error,
                        m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tdata[23:8]));
            end
        end
        rx_tick++;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ((rx_tick % 16) >= 5);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    initial begin
        // counts while idle, then a full run on the reset settings
        add_row(OP_COUNT, 16'd0,     1'b1, 8'd224, 1'b0, 16'd12800);
        add_row(OP_COUNT, 16'hFFFF,  1'b1, 8'd224, 1'b0, 16'd52735);
        add_row(OP_START, 16'hFFFF,  1'b1, 8'd224, 1'b0, 16'd0);
        add_row(OP_COUNT, 16'd12345, 1'b1, 8'd224, 1'b0, 16'd455);
        add_row(OP_COUNT, 16'd12000, 1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd13000, 1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd12800, 1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd0,     1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'hFFFF,  1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd12799, 1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd12810, 1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd12790, 1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd12805, 1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd12800, 1'b0, '0, 1'b0, '0);
        // restart in the middle of a search
        add_row(OP_START, 16'd0,     1'b1, 8'd224, 1'b0, 16'd0);
        add_row(OP_COUNT, 16'd1000,  1'b1, 8'd224, 1'b0, 16'd11800);
        add_row(OP_COUNT, 16'd20000, 1'b0, '0, 1'b0, '0);
        add_row(OP_START, 16'h5A5A,  1'b1, 8'd224, 1'b0, 16'd0);
        add_row(OP_COUNT, 16'd40000, 1'b1, 8'd224, 1'b0, 16'd27200);
        add_row(OP_COUNT, 16'd12801, 1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd12799, 1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd100,   1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd60000, 1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd12800, 1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd12800, 1'b0, '0, 1'b0, '0);
        // three equal errors: minus neighbour must win
        add_row(OP_COUNT, 16'd12810, 1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd12790, 1'b0, '0, 1'b0, '0);
        add_row(OP_COUNT, 16'd12790, 1'b0, '0, 1'b0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rx_mode = 1;
        for (int k = 0; k < dir_rows.size(); k++)
            send_word(dir_rows[k].op, dir_rows[k].cnt, dir_rows[k].lit, dir_rows[k].res);
        s_axis_tvalid <= 1'b0;

        apply_config(16'd1, 8'd0, 8'd128);
        rx_mode = 0;
        run_random(230);
        apply_config(16'hFFFF, 8'hFF, 8'd1);
        rx_mode = 2;
        run_random(230);
        apply_config(16'd0, 8'd128, 8'd0);
        rx_mode = 3;
        run_random(230);
        apply_config(16'($urandom), 8'($urandom), 8'hFF);
        rx_mode = 1;
        run_random(230);
        apply_config(16'($urandom), 8'($urandom), 8'($urandom_range(3, 127)));
        rx_mode = 2;
        run_random(230);
        apply_config(TARGET_RST, TRIM_RST, STEP_RST);
        rx_mode = 1;
        run_random(230);

        while (trim_expect_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (trim_expect_q.size() != 0) report_miss("expected words left over");

        $display("covered %0d input words and %0d result words over %0d register settings",
                 words_sent, words_checked, config_sets + 1);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("oscillator_trim_calibrator_unit_test: PASS");
        end else begin
            $display("oscillator_trim_calibrator_unit_test: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/otc_pkg.sv
rtl/otc_step.sv
rtl/oscillator_trim_calibrator_unit.sv
rtl/otc_checker.sv
tb/oscillator_trim_calibrator_unit_test.sv
